// ===== src/combined_lcg_shuffle_rng_defines.svh =====
// assertion macros for the combined lcg shuffle generator
`ifndef COMBINED_LCG_SHUFFLE_RNG_DEFINES_SVH
`define COMBINED_LCG_SHUFFLE_RNG_DEFINES_SVH

// same-cycle implication, disabled during reset
`define CLSR_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("clsr assertion failed");

// next-cycle implication, disabled during reset
`define CLSR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("clsr assertion failed");

`endif

// ===== src/clsr_pkg.sv =====
// shared constants and types for the combined lcg shuffle generator
`default_nettype none

package clsr_pkg;

  localparam logic [30:0] MOD1  = 31'd2147483563;
  localparam logic [30:0] MOD2  = 31'd2147483399;
  localparam logic [30:0] RANGE = 31'd2147483562;
  localparam logic [15:0] MUL1  = 16'd40014;
  localparam logic [15:0] MUL2  = 16'd40692;
  // 2^31 mod each prime, used to fold the upper product bits
  localparam logic [7:0]  FOLD1 = 8'd85;
  localparam logic [7:0]  FOLD2 = 8'd249;
  // warm-up steps beyond the table depth
  localparam int unsigned WARMUP = 8;

  typedef enum logic {
    GEN_FIRST,
    GEN_SECOND
  } gen_sel_t;

  typedef struct packed {
    logic        go;
    gen_sel_t    sel;
    logic [30:0] value;
  } mm_req_t;

  typedef struct packed {
    logic        done;
    logic [30:0] value;
  } mm_rsp_t;

endpackage

`default_nettype wire

// ===== src/clsr_if.sv =====
// valid/ready channel interfaces for request and sample items
`default_nettype none

interface clsr_in_if;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface clsr_out_if;
  logic        valid;
  logic        ready;
  logic [30:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

`default_nettype wire

// ===== src/combined_lcg_shuffle_rng.sv =====
// top level: combined lcg generator with shuffle table and draw sequencer
//
// usage:
//   in_ch carries one request item per draw; restart = 1 reloads both
//   generators and the shuffle table from the seed register first.
//   out_ch returns one sample item per request, a value in 1..2147483562.
//   cfg_wen/cfg_wdata write the seed; write only while no draw is pending.
// sequencing:
//   a draw runs two multiplier passes, first generator then second, on the
//   shared modular multiplier, then the table read-modify-write; the slot
//   lookup runs beside. a new request is accepted only once the previous
//   sample has moved to the output register. initialization (first item
//   after reset or restart) adds one multiplier pass per warm-up step.
// reset:
//   rst clears the sequencer and sets the seed to 1; the table is filled on
//   the first item.
// stall:
//   a sample waits in the output register; the next item is accepted, and
//   its sample holds in the sequencer until the register frees.
`default_nettype none
`include "combined_lcg_shuffle_rng_defines.svh"

module combined_lcg_shuffle_rng #(
  parameter int TABLE_DEPTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wen,
  input  wire logic [30:0] cfg_wdata,
  clsr_in_if.sink          in_ch,
  clsr_out_if.source       out_ch
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int NW = $clog2(TABLE_DEPTH + clsr_pkg::WARMUP);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT_ISSUE,
    ST_INIT_WAIT,
    ST_DRAW_ISSUE,
    ST_DRAW_WAIT1,
    ST_DRAW_WAIT2,
    ST_READ,
    ST_DIFF,
    ST_DONE
  } state_t;

  state_t      state;
  logic [30:0] seed;
  logic [30:0] g1;
  logic [30:0] g2;
  logic [30:0] last_output;
  logic        initialized;
  logic [NW-1:0] n;
  logic        out_valid;
  logic [30:0] sample;

  logic [30:0] shuffle_mem [TABLE_DEPTH];
  logic [30:0] mem_rdata;
  logic        mem_we;
  logic        mem_re;
  logic [AW-1:0] mem_waddr;
  logic [30:0] mem_wdata;

  clsr_pkg::mm_req_t mm_req;
  clsr_pkg::mm_rsp_t mm_rsp;

  logic          div_start;
  logic          div_busy;
  logic [AW-1:0] slot;

  logic [30:0] start_value;
  logic [31:0] diff;

  clsr_mulmod u_mulmod (
    .clk (clk),
    .rst (rst),
    .req (mm_req),
    .rsp (mm_rsp)
  );

  clsr_slot_div #(
    .DEPTH (TABLE_DEPTH)
  ) u_slot_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .x     (last_output),
    .busy  (div_busy),
    .slot  (slot)
  );

  assign start_value = (seed == 31'd0) ? 31'd1 : seed;
  assign diff = (mem_rdata > g2) ? 32'(mem_rdata) - 32'(g2)
                                 : 32'(mem_rdata) + 32'(clsr_pkg::RANGE) - 32'(g2);

  assign in_ch.ready   = (state == ST_IDLE);
  assign out_ch.valid  = out_valid;
  assign out_ch.sample = sample;
  assign div_start     = (state == ST_DRAW_ISSUE);

  always_comb begin
    mm_req = '{go: 1'b0, sel: clsr_pkg::GEN_FIRST, value: g1};
    unique case (state) inside
      ST_INIT_ISSUE, ST_DRAW_ISSUE: begin
        mm_req.go = 1'b1;
      end
      ST_DRAW_WAIT1: begin
        mm_req = '{go: mm_rsp.done, sel: clsr_pkg::GEN_SECOND, value: g2};
      end
      default: begin
        mm_req.go = 1'b0;
      end
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = slot;
    mem_wdata = g1;
    unique case (state)
      ST_INIT_WAIT: begin
        mem_we    = mm_rsp.done && (n < NW'(TABLE_DEPTH));
        mem_waddr = n[AW-1:0];
        mem_wdata = mm_rsp.value;
      end
      ST_READ: begin
        mem_re = !div_busy;
      end
      ST_DIFF: begin
        mem_we = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      shuffle_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= shuffle_mem[slot];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= 31'd1;
    end else if (cfg_wen) begin
      seed <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      g1          <= '0;
      g2          <= '0;
      last_output <= '0;
      initialized <= 1'b0;
      n           <= '0;
      out_valid   <= 1'b0;
      sample      <= '0;
    end else begin
      if (out_valid && out_ch.ready && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_ch.valid) begin
            if (in_ch.restart || !initialized) begin
              g1    <= start_value;
              g2    <= start_value;
              n     <= NW'(TABLE_DEPTH + clsr_pkg::WARMUP - 1);
              state <= ST_INIT_ISSUE;
            end else begin
              state <= ST_DRAW_ISSUE;
            end
          end
        end
        ST_INIT_ISSUE: begin
          state <= ST_INIT_WAIT;
        end
        ST_INIT_WAIT: begin
          if (mm_rsp.done) begin
            g1 <= mm_rsp.value;
            if (n == '0) begin
              last_output <= mm_rsp.value;
              initialized <= 1'b1;
              state       <= ST_DRAW_ISSUE;
            end else begin
              n     <= n - NW'(1);
              state <= ST_INIT_ISSUE;
            end
          end
        end
        ST_DRAW_ISSUE: begin
          state <= ST_DRAW_WAIT1;
        end
        ST_DRAW_WAIT1: begin
          if (mm_rsp.done) begin
            g1    <= mm_rsp.value;
            state <= ST_DRAW_WAIT2;
          end
        end
        ST_DRAW_WAIT2: begin
          if (mm_rsp.done) begin
            g2    <= mm_rsp.value;
            state <= ST_READ;
          end
        end
        ST_READ: begin
          if (!div_busy) begin
            state <= ST_DIFF;
          end
        end
        ST_DIFF: begin
          last_output <= diff[30:0];
          state       <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid || out_ch.ready) begin
            out_valid <= 1'b1;
            sample    <= last_output;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `CLSR_ASSERT_NOW(a_sample_range, clk, rst, out_valid,
                   (sample != 31'd0) && (sample <= clsr_pkg::RANGE))
  `CLSR_ASSERT_NOW(a_mm_reduced, clk, rst, mm_rsp.done, mm_rsp.value < clsr_pkg::MOD1)
  `CLSR_ASSERT_NOW(a_mm_quiet_idle, clk, rst, state == ST_IDLE, !mm_rsp.done)
  `CLSR_ASSERT_NEXT(a_slot_ready, clk, rst, state == ST_READ && !div_busy,
                    state == ST_DIFF && !div_busy)

endmodule

`default_nettype wire

// ===== src/clsr_mulmod.sv =====
// shared two-stage modular multiplier for both generators
`default_nettype none

module clsr_mulmod (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire clsr_pkg::mm_req_t req,
  output clsr_pkg::mm_rsp_t      rsp
);

  logic               stage1_valid;
  clsr_pkg::gen_sel_t sel_q;
  logic [46:0]        prod;
  logic               done_q;
  logic [30:0]        res_q;

  logic [15:0] mult;
  logic [15:0] hi;
  logic [30:0] lo;
  logic [23:0] fold;
  logic [7:0]  fold_c;
  logic [30:0] modulus;
  logic [31:0] sum;
  logic [31:0] red;

  assign mult = (req.sel == clsr_pkg::GEN_SECOND) ? clsr_pkg::MUL2 : clsr_pkg::MUL1;

  always_comb begin
    fold_c  = (sel_q == clsr_pkg::GEN_SECOND) ? clsr_pkg::FOLD2 : clsr_pkg::FOLD1;
    modulus = (sel_q == clsr_pkg::GEN_SECOND) ? clsr_pkg::MOD2 : clsr_pkg::MOD1;
    hi      = prod[46:31];
    lo      = prod[30:0];
    fold    = 24'(hi) * 24'(fold_c);
    sum     = 32'(lo) + 32'(fold);
    red     = (sum >= 32'(modulus)) ? sum - 32'(modulus) : sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage1_valid <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      stage1_valid <= req.go;
      done_q       <= stage1_valid;
    end
    if (req.go) begin
      prod  <= 47'(req.value) * 47'(mult);
      sel_q <= req.sel;
    end
    if (stage1_valid) begin
      res_q <= red[30:0];
    end
  end

  assign rsp.done  = done_q;
  assign rsp.value = res_q;

endmodule

`default_nettype wire

// ===== src/clsr_slot_div.sv =====
// reciprocal-multiply lookup that turns the previous sample into a table slot
`default_nettype none

module clsr_slot_div #(
  parameter int DEPTH = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [30:0]                x,
  output logic                            busy,
  output logic [$clog2(DEPTH)-1:0]        slot
);

  localparam int AW = $clog2(DEPTH);
  localparam int QW = AW + 1;
  localparam int PW = 31 + QW;
  localparam int TW = 32 + QW;
  localparam logic [31:0] BUCKET = 32'd1 + {1'b0, clsr_pkg::RANGE} / 32'(DEPTH);
  // floor(2^31 / bucket), the estimate is low by at most one
  localparam logic [63:0] RECIP_FULL = 64'h8000_0000 / {32'd0, BUCKET};
  localparam logic [QW-1:0] RECIP = RECIP_FULL[QW-1:0];

  logic [30:0]   x_q;
  logic [QW-1:0] est_q;
  logic [PW-1:0] prod;
  logic [TW-1:0] bound;
  logic [QW-1:0] q;

  assign prod  = PW'(x) * PW'(RECIP);
  assign bound = (TW'(est_q) + TW'(1)) * TW'(BUCKET);
  assign q     = est_q + QW'(TW'(x_q) >= bound);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy  <= 1'b1;
      x_q   <= x;
      est_q <= prod[PW-1:31];
    end else if (busy) begin
      busy <= 1'b0;
      // clamp to the top entry
      slot <= (q >= QW'(DEPTH)) ? AW'(DEPTH - 1) : q[AW-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/tb_combined_lcg_shuffle_rng.sv =====
// testbench for the combined lcg shuffle generator: directed table, random seeds and stalls
`timescale 1ns / 100ps

module tb_combined_lcg_shuffle_rng;

  localparam int TABLE_DEPTH = 32;
  localparam int unsigned BUCKET = 1 + int'(clsr_pkg::RANGE) / TABLE_DEPTH;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int N_DIRECTED = 20;

  typedef struct packed {
    logic        wr;
    logic [30:0] seed;
    logic        restart;
    logic        known;
    logic [30:0] sample;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wen;
  logic [30:0] cfg_wdata;

  clsr_in_if req_ch ();
  clsr_out_if smp_ch ();

  combined_lcg_shuffle_rng #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_wen(cfg_wen),
    .cfg_wdata(cfg_wdata),
    .in_ch(req_ch),
    .out_ch(smp_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // generator state mirror
  logic [30:0] seed_reg = 31'd1;
  logic [30:0] gen1 = '0;
  logic [30:0] gen2 = '0;
  logic [30:0] prev_sample = '0;
  logic [30:0] shuffle [TABLE_DEPTH];
  bit primed = 1'b0;

  logic [30:0] pending_samples [$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_gap_pct = 29;
  int unsigned sink_stall_pct = 59;

  row_t directed_rows [N_DIRECTED] = '{
    '{1'b0, 31'd0, 1'b0, 1'b0, 31'd0},
    '{1'b0, 31'd0, 1'b0, 1'b0, 31'd0},
    '{1'b0, 31'd0, 1'b1, 1'b0, 31'd0},
    '{1'b1, 31'd0, 1'b1, 1'b0, 31'd0},
    '{1'b0, 31'd0, 1'b0, 1'b0, 31'd0},
    '{1'b1, clsr_pkg::MOD1, 1'b0, 1'b0, 31'd0},
    '{1'b0, 31'd0, 1'b1, 1'b1, 31'd2140810074},
    '{1'b0, 31'd0, 1'b0, 1'b0, 31'd0},
    '{1'b0, 31'd0, 1'b0, 1'b0, 31'd0},
    '{1'b1, clsr_pkg::MOD2, 1'b1, 1'b0, 31'd0},
    '{1'b0, 31'd0, 1'b0, 1'b0, 31'd0},
    '{1'b1, 31'h7FFFFFFF, 1'b1, 1'b0, 31'd0},
    '{1'b0, 31'd0, 1'b0, 1'b0, 31'd0},
    '{1'b1, clsr_pkg::RANGE, 1'b1, 1'b0, 31'd0},
    '{1'b0, 31'd0, 1'b0, 1'b0, 31'd0},
    '{1'b1, 31'h2AAAAAAA, 1'b1, 1'b0, 31'd0},
    '{1'b1, 31'h55555555, 1'b1, 1'b0, 31'd0},
    '{1'b0, 31'd0, 1'b0, 1'b0, 31'd0},
    '{1'b1, 31'd12345, 1'b0, 1'b0, 31'd0},
    '{1'b0, 31'd0, 1'b1, 1'b0, 31'd0}
  };

  function automatic logic [30:0] mulmod(input logic [30:0] v, input logic [15:0] m,
                                         input logic [30:0] p);
    longint unsigned prod;
    prod = longint'(v) * longint'(m);
    return 31'(prod % longint'(p));
  endfunction

  function automatic logic [30:0] draw_uniform(input bit reload);
    logic [30:0] start;
    int unsigned slot;
    longint diff;
    if (!primed || reload) begin
      start = (seed_reg == '0) ? 31'd1 : seed_reg;
      gen1 = start;
      gen2 = start;
      for (int n = TABLE_DEPTH + clsr_pkg::WARMUP - 1; n >= 0; n--) begin
        gen1 = mulmod(gen1, clsr_pkg::MUL1, clsr_pkg::MOD1);
        if (n < TABLE_DEPTH) begin
          shuffle[n] = gen1;
        end
      end
      prev_sample = shuffle[0];
      primed = 1'b1;
    end
    gen1 = mulmod(gen1, clsr_pkg::MUL1, clsr_pkg::MOD1);
    gen2 = mulmod(gen2, clsr_pkg::MUL2, clsr_pkg::MOD2);
    slot = int'(prev_sample) / BUCKET;
    if (slot >= TABLE_DEPTH) begin
      slot = TABLE_DEPTH - 1;
    end
    diff = longint'(shuffle[slot]) - longint'(gen2);
    if (diff < 1) begin
      diff += longint'(clsr_pkg::RANGE);
    end
    prev_sample = diff[30:0];
    shuffle[slot] = gen1;
    return prev_sample;
  endfunction

  task automatic send_request(input bit rs, input bit known, input logic [30:0] typed);
    logic [30:0] want;
    while ($urandom_range(0, 99) < send_gap_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.restart <= rs;
    @(posedge clk);
    while (!req_ch.ready) begin
      @(posedge clk);
    end
    want = draw_uniform(rs);
    if (known) begin
      want = typed;
    end
    pending_samples.push_back(want);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    while (pending_samples.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_seed(input logic [30:0] v);
    drain();
    cfg_wen <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen <= 1'b0;
    seed_reg = v;
  endtask

  // sample checker and receiver stalls
  always @(posedge clk) begin
    logic [30:0] want;
    if (!rst && smp_ch.valid && smp_ch.ready) begin
      if (pending_samples.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected sample, expected none, got %0d", $time, smp_ch.sample);
      end else begin
        want = pending_samples.pop_front();
        if (smp_ch.sample !== want) begin
          mismatch_count++;
          $display("%0t: sample mismatch, expected %0d, got %0d", $time, want,
                   smp_ch.sample);
        end
      end
    end
    smp_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    logic [30:0] next_seed;
    req_ch.valid <= 1'b0;
    req_ch.restart <= 1'b0;
    cfg_wen <= 1'b0;
    cfg_wdata <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].wr) begin
        write_seed(directed_rows[i].seed);
      end
      send_request(directed_rows[i].restart, directed_rows[i].known,
                   directed_rows[i].sample);
    end

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_gap_pct = 29;
          sink_stall_pct = 59;
        end
        1: begin
          send_gap_pct = 59;
          sink_stall_pct = 29;
        end
        default: begin
          send_gap_pct = 0;
          sink_stall_pct = 0;
        end
      endcase
      for (int chunk = 0; chunk < 10; chunk++) begin
        case ($urandom_range(0, 9))
          0: next_seed = '0;
          1: next_seed = clsr_pkg::MOD1;
          2: next_seed = clsr_pkg::MOD2;
          3: next_seed = '1;
          4: next_seed = 31'd1;
          5: next_seed = 31'($urandom_range(1, int'(clsr_pkg::RANGE)));
          default: next_seed = 31'($urandom);
        endcase
        write_seed(next_seed);
        for (int k = 0; k < 58; k++) begin
          send_request((k == 0) ? bit'($urandom_range(0, 1)) : ($urandom_range(0, 11) == 0),
                       1'b0, '0);
        end
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && pending_samples.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
